// ===== sv/integer_divide_modulus_defines.svh =====
// assertion macros used by the checker file
`ifndef INTEGER_DIVIDE_MODULUS_DEFINES_SVH
`define INTEGER_DIVIDE_MODULUS_DEFINES_SVH

// same-cycle implication, checked once out of reset
`define IDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked once out of reset
`define IDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/idm_pkg.sv =====
// shared types and constants for the pipelined divider
`default_nettype none

package idm_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int MODE_WIDTH  = 2;
    localparam int DIV_STAGES  = DATA_WIDTH;
    localparam int IN_FIELDS_W = MODE_WIDTH + 2 * DATA_WIDTH;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_DIVU = 2'd0,
        MODE_DIV  = 2'd1,
        MODE_REMU = 2'd2,
        MODE_REM  = 2'd3
    } mode_t;

    // payload carried from stage to stage
    typedef struct packed {
        logic                  want_rem;
        logic                  q_neg;
        logic                  r_neg;
        logic                  div_zero;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dvs;
    } stage_t;

endpackage

`default_nettype wire

// ===== sv/integer_divide_modulus.sv =====
// Throughput: one transfer per cycle; one restoring step per stage over 32 stages,
// plus a sign/magnitude stage in front and a sign fix/select stage at the output.
// A stall on the output side freezes the whole pipeline and holds s_axis_tready low.
// Reset clears the stage valid bits and the output valid; payload is not reset.
`default_nettype none

module integer_divide_modulus
    import idm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode, dividend, divisor, zero pad
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // result
);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic stage_t div_step(input stage_t s);
        logic [DATA_WIDTH:0]   shifted;
        logic [DATA_WIDTH+1:0] diff;
        stage_t                o;
        shifted = {s.rem, s.nq[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, s.dvs};
        o       = s;
        o.nq    = {s.nq[DATA_WIDTH-2:0], ~diff[DATA_WIDTH+1]};
        o.rem   = diff[DATA_WIDTH+1] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        return o;
    endfunction

    logic                  adv;
    mode_t                 mode;
    logic                  is_signed;
    logic                  want_rem;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    logic                  a_neg;
    logic                  b_neg;
    stage_t                entry;
    stage_t                last;
    logic [DATA_WIDTH-1:0] rem_fix;
    logic [DATA_WIDTH-1:0] quo_fix;

    stage_t                pipe_reg  [0:DIV_STAGES];
    stage_t                pipe_next [0:DIV_STAGES];
    logic [DIV_STAGES:0]   vld_reg;
    logic [DIV_STAGES:0]   vld_next;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [DATA_WIDTH-1:0] result_reg;
    logic [DATA_WIDTH-1:0] result_next;

    // whole pipeline moves unless the output holds an untaken result
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(result_reg);

    assign mode     = mode_t'(s_axis_tdata[MODE_WIDTH-1:0]);
    assign dividend = s_axis_tdata[MODE_WIDTH +: DATA_WIDTH];
    assign divisor  = s_axis_tdata[MODE_WIDTH+DATA_WIDTH +: DATA_WIDTH];

    always_comb
    begin
        unique case (mode)
            MODE_DIVU:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b0;
            end
            MODE_DIV:
            begin
                is_signed = 1'b1;
                want_rem  = 1'b0;
            end
            MODE_REMU:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b1;
            end
            MODE_REM:
            begin
                is_signed = 1'b1;
                want_rem  = 1'b1;
            end
            default:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b0;
            end
        endcase
    end

    // magnitudes; the most negative value keeps its pattern
    always_comb
    begin
        a_neg          = is_signed && dividend[DATA_WIDTH-1];
        b_neg          = is_signed && divisor[DATA_WIDTH-1];
        entry.want_rem = want_rem;
        entry.q_neg    = a_neg ^ b_neg;
        entry.r_neg    = a_neg;
        entry.div_zero = (divisor == '0);
        entry.nq       = a_neg ? (DATA_WIDTH'(0) - dividend) : dividend;
        entry.rem      = '0;
        entry.dvs      = b_neg ? (DATA_WIDTH'(0) - divisor) : divisor;
    end

    always_comb
    begin
        pipe_next[0] = entry;
        vld_next[0]  = s_axis_tvalid;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            pipe_next[k] = div_step(pipe_reg[k-1]);
            vld_next[k]  = vld_reg[k-1];
        end
    end

    // sign fix and quotient/remainder select; a zero divisor gives a zero result
    always_comb
    begin
        last         = pipe_reg[DIV_STAGES];
        rem_fix      = last.r_neg ? (DATA_WIDTH'(0) - last.rem) : last.rem;
        quo_fix      = last.q_neg ? (DATA_WIDTH'(0) - last.nq) : last.nq;
        out_vld_next = vld_reg[DIV_STAGES];
        if (last.div_zero)
        begin
            result_next = '0;
        end
        else if (last.want_rem)
        begin
            result_next = rem_fix;
        end
        else
        begin
            result_next = quo_fix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/idm_checker.sv =====
// port-level checks for the pipelined divider, bound to the top level
`default_nettype none

`include "integer_divide_modulus_defines.svh"

module idm_checker
    import idm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode, dividend, divisor, zero pad
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata   // result
);

    logic out_stall;
    logic in_xfer;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    `IDM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "result dropped while stalled")
    `IDM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(m_axis_tdata), "result changed while stalled")
    `IDM_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
    `IDM_ASSERT_NOW(a_no_take_on_stall, clk, rst_n, out_stall, !s_axis_tready && !in_xfer, "input taken while output stalled")
    `IDM_ASSERT_NOW(a_in_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tdata), "unknown bits in offered input")

endmodule

bind integer_divide_modulus idm_checker u_idm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
